[hdl/tdss_pkg.sv]
// ----------------------------------------------------------------------------
// tdss_pkg
// Shared types and constants for the tick-divided service scheduler.
// ----------------------------------------------------------------------------
package tdss_pkg;

  // Number of tick sources, each with its own slot table
  localparam int NUM_SOURCES = 2;
  // Width used to compare a tick count against an interval
  localparam int CMP_W = 32;
  // Field widths of the item ports
  localparam int OP_W       = 2;
  localparam int SLOT_OUT_W = 3;
  localparam int IVL_W      = 31;
  localparam int MASK_W     = 8;
  localparam int ACTIVE_W   = 4;
  localparam int ACTIVE_MAX = 15;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 2'd0,
    OP_REGISTER   = 2'd1,
    OP_UNREGISTER = 2'd2,
    OP_DONE       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_NO_FREE     = 2'd2,
    ST_NOT_REG     = 2'd3
  } status_e;

  // Per-slot command, one strobe per action
  typedef struct packed {
    logic tick;    // advance count, may fire
    logic load;    // take the slot with a new interval
    logic clear;   // release the slot
    logic unbusy;  // service finished
  } slot_cmd_t;

endpackage

[hdl/tdss_slot.sv]
// ----------------------------------------------------------------------------
// tdss_slot
// One service slot: valid, interval, saturating tick count and busy bit.
// ----------------------------------------------------------------------------
module tdss_slot import tdss_pkg::*; #(
  parameter int TICK_COUNT_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slot_cmd_t        cmd_i,
  input  logic [IVL_W-1:0] interval_i,
  output logic             valid_o,
  output logic             fire_o
);

  logic                       valid_q, valid_d;
  logic                       busy_q, busy_d;
  logic [IVL_W-1:0]           interval_q, interval_d;
  logic [TICK_COUNT_BITS-1:0] ticks_q, ticks_d;
  logic [TICK_COUNT_BITS-1:0] ticks_inc;
  logic                       reached;

  // Saturating increment and interval compare
  assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
  assign reached   = CMP_W'(ticks_inc) >= CMP_W'(interval_q);
  assign fire_o    = cmd_i.tick && valid_q && !busy_q && reached;
  assign valid_o   = valid_q;

  // Next state
  always_comb begin
    valid_d    = valid_q;
    busy_d     = busy_q;
    interval_d = interval_q;
    ticks_d    = ticks_q;
    if (cmd_i.tick && valid_q) begin
      ticks_d = fire_o ? '0 : ticks_inc;
      busy_d  = busy_q | fire_o;
    end
    if (cmd_i.load) begin
      valid_d    = 1'b1;
      busy_d     = 1'b0;
      interval_d = interval_i;
      ticks_d    = '0;
    end
    if (cmd_i.clear) begin
      valid_d    = 1'b0;
      busy_d     = 1'b0;
      interval_d = '0;
      ticks_d    = '0;
    end
    if (cmd_i.unbusy) begin
      busy_d = 1'b0;
    end
  end

  // Control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      busy_q  <= busy_d;
    end
  end

  // Payload, only meaningful while valid
  always_ff @(posedge clk_i) begin
    interval_q <= interval_d;
    ticks_q    <= ticks_d;
  end

endmodule

[hdl/tick_divided_service_scheduler.sv]
// ----------------------------------------------------------------------------
// tick_divided_service_scheduler
// Two tick sources, each with a table of service slots that fire on interval.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: op, timer_sel,
//   slot_index and interval. Ops are tick, register, unregister and done.
//   Output channel (out_valid_o / out_ready_i) returns one result per item:
//   status, slot_out, fire_mask and active_count of the addressed source.
//   Path: an accepted item lands in an input register, is processed by
//   the per-slot logic and its result is registered in the result
//   register, which drives the outputs.
//   Throughput: one item per cycle unless the receiver stalls; all
//   slots of a source update in parallel and a priority encoder picks
//   the lowest free slot for register.
//   When the receiver stalls, the result register holds, the input register
//   fills and in_ready_o drops; nothing is lost or repeated.
//   Reset clears all slot valid and busy bits, the active counters and both
//   valid flags; the block accepts items right after reset.
// ----------------------------------------------------------------------------
module tick_divided_service_scheduler import tdss_pkg::*; #(
  parameter int SLOTS_PER_SOURCE = 8,
  parameter int TICK_COUNT_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic                  timer_sel_i,
  input  logic [2:0]            slot_index_i,
  input  logic [IVL_W-1:0]      interval_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [SLOT_OUT_W-1:0] slot_out_o,
  output logic [MASK_W-1:0]     fire_mask_o,
  output logic [ACTIVE_W-1:0]   active_count_o
);

  localparam int IDX_W = (SLOTS_PER_SOURCE > 1) ? $clog2(SLOTS_PER_SOURCE) : 1;
  localparam int CNT_W = $clog2(SLOTS_PER_SOURCE + 1);

  // Input register
  logic                 in_valid_q;
  op_e                  op_q;
  logic                 sel_q;
  logic [2:0]           idx_q;
  logic [IVL_W-1:0]     ivl_q;

  // Result register
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic [SLOT_OUT_W-1:0] slot_q, slot_d;
  logic [MASK_W-1:0]     mask_q, mask_d;
  logic [ACTIVE_W-1:0]   active_q, active_d;

  // Active slot counters, one per source
  logic [CNT_W-1:0] cnt_q [NUM_SOURCES];
  logic [CNT_W-1:0] cnt_d [NUM_SOURCES];

  // Slot table
  slot_cmd_t                            cmd [NUM_SOURCES][SLOTS_PER_SOURCE];
  logic [NUM_SOURCES-1:0][SLOTS_PER_SOURCE-1:0] slot_valid;
  logic [NUM_SOURCES-1:0][SLOTS_PER_SOURCE-1:0] slot_fire;

  logic                        proceed;
  logic [SLOTS_PER_SOURCE-1:0] src_valid;
  logic                        found;
  logic [IDX_W-1:0]            first;
  logic                        idx_ok;
  logic [IDX_W-1:0]            idx_tgt;
  logic                        tgt_valid;
  logic                        do_load;
  logic                        do_clear;
  logic                        do_unbusy;
  logic [MASK_W-1:0]           src_mask;
  logic [CNT_W-1:0]            cnt_sel;

  // Handshake
  assign proceed    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proceed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q  <= op_e'(op_i);
      sel_q <= timer_sel_i;
      idx_q <= slot_index_i;
      ivl_q <= interval_i;
    end
  end

  // Lowest free slot on the addressed source
  assign src_valid = slot_valid[sel_q];
  always_comb begin
    found = 1'b0;
    first = '0;
    for (int i = SLOTS_PER_SOURCE - 1; i >= 0; i--) begin
      if (!src_valid[i]) begin
        found = 1'b1;
        first = IDX_W'(i);
      end
    end
  end

  // Target slot lookup for unregister and done
  assign idx_ok    = {3'b000, idx_q} < 6'(SLOTS_PER_SOURCE);
  assign idx_tgt   = IDX_W'(idx_q);
  assign tgt_valid = idx_ok && src_valid[idx_tgt];

  // Decode item into actions and status
  always_comb begin
    do_load   = 1'b0;
    do_clear  = 1'b0;
    do_unbusy = 1'b0;
    status_d  = ST_OK;
    slot_d    = idx_q;
    unique case (op_q)
      OP_TICK: begin
        status_d = ST_OK;
      end
      OP_REGISTER: begin
        if (ivl_q == '0) begin
          status_d = ST_INVALID;
        end else if (!found) begin
          status_d = ST_NO_FREE;
        end else begin
          do_load = 1'b1;
          slot_d  = SLOT_OUT_W'(first);
        end
      end
      OP_UNREGISTER, OP_DONE: begin
        if (!idx_ok) begin
          status_d = ST_INVALID;
        end else if (!tgt_valid) begin
          status_d = ST_NOT_REG;
        end else if (op_q == OP_UNREGISTER) begin
          do_clear = 1'b1;
        end else begin
          do_unbusy = 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Per-slot commands
  always_comb begin
    for (int s = 0; s < NUM_SOURCES; s++) begin
      for (int i = 0; i < SLOTS_PER_SOURCE; i++) begin
        cmd[s][i].tick   = proceed && (op_q == OP_TICK) && (sel_q == 1'(s));
        cmd[s][i].load   = proceed && do_load && (sel_q == 1'(s))
                           && (first == IDX_W'(i));
        cmd[s][i].clear  = proceed && do_clear && (sel_q == 1'(s))
                           && ({3'b000, idx_q} == 6'(i));
        cmd[s][i].unbusy = proceed && do_unbusy && (sel_q == 1'(s))
                           && ({3'b000, idx_q} == 6'(i));
      end
    end
  end

  // Slot lanes
  for (genvar s = 0; s < NUM_SOURCES; s++) begin : g_src
    for (genvar i = 0; i < SLOTS_PER_SOURCE; i++) begin : g_slot
      tdss_slot #(
        .TICK_COUNT_BITS(TICK_COUNT_BITS)
      ) u_slot (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .cmd_i      (cmd[s][i]),
        .interval_i (ivl_q),
        .valid_o    (slot_valid[s][i]),
        .fire_o     (slot_fire[s][i])
      );
    end
  end

  // Fire mask covers the low slots only
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < SLOTS_PER_SOURCE) begin : g_on
      assign src_mask[b] = slot_fire[sel_q][b];
    end else begin : g_off
      assign src_mask[b] = 1'b0;
    end
  end
  assign mask_d = (op_q == OP_TICK) ? src_mask : '0;

  // Active counters
  always_comb begin
    for (int s = 0; s < NUM_SOURCES; s++) begin
      cnt_d[s] = cnt_q[s];
    end
    if (proceed && do_load) begin
      cnt_d[sel_q] = cnt_q[sel_q] + 1'b1;
    end else if (proceed && do_clear) begin
      cnt_d[sel_q] = cnt_q[sel_q] - 1'b1;
    end
    cnt_sel  = cnt_d[sel_q];
    active_d = (CNT_W'(ACTIVE_MAX) < cnt_sel && CNT_W > ACTIVE_W) ?
               ACTIVE_W'(ACTIVE_MAX) : ACTIVE_W'(cnt_sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        cnt_q[s] <= '0;
      end
    end else begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        cnt_q[s] <= cnt_d[s];
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (proceed) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      mask_q   <= mask_d;
      active_q <= active_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_out_o     = slot_q;
  assign fire_mask_o    = mask_q;
  assign active_count_o = active_q;

`ifndef SYNTHESIS
  // Counters track the valid bits of each table
  a_cnt0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q[0]) == 32'($countones(slot_valid[0])))
    else $error("active counter of source 0 out of step with slot table");

  a_cnt1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q[1]) == 32'($countones(slot_valid[1])))
    else $error("active counter of source 1 out of step with slot table");

  // Only a stalled result may hold off new items
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && in_valid_q))
    else $error("input stalled without a stalled result");

  // Fired slots only ever come with an ok status
  a_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fire_mask_o != '0) |-> (status_o == ST_OK))
    else $error("fire mask set on a failed item");
`endif

endmodule

[tb/sv/tick_divided_service_scheduler_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tick_divided_service_scheduler_test
// Self-checking bench: drives tick, register, unregister and done items with
// random idle gaps on both channels, predicts every result from a shadow copy
// of both slot tables and compares each returned result field by field.
// ----------------------------------------------------------------------------
module tick_divided_service_scheduler_test import tdss_pkg::*;;

  localparam int SLOTS       = 8;
  localparam int TABLE_DEPTH = NUM_SOURCES * SLOTS;
  localparam int STALL_LIMIT = 1000;
  localparam logic [CMP_W-1:0] COUNT_MAX = '1;

  typedef struct {
    status_e               status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [MASK_W-1:0]     mask;
    logic [ACTIVE_W-1:0]   active;
  } sched_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [OP_W-1:0]       op_i;
  logic                  timer_sel_i;
  logic [2:0]            slot_index_i;
  logic [IVL_W-1:0]      interval_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [1:0]            status_o;
  logic [SLOT_OUT_W-1:0] slot_out_o;
  logic [MASK_W-1:0]     fire_mask_o;
  logic [ACTIVE_W-1:0]   active_count_o;

  // Shadow slot tables, indexed by source * SLOTS + slot
  bit             slot_used   [TABLE_DEPTH];
  bit [IVL_W-1:0] slot_period [TABLE_DEPTH];
  bit [CMP_W-1:0] slot_count  [TABLE_DEPTH];
  bit             slot_pending[TABLE_DEPTH];

  sched_result_t  pending_results[$];
  int             fail_count = 0;
  int             quiet_cycles = 0;
  bit             idle_en = 1'b1;

  tick_divided_service_scheduler u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .timer_sel_i    (timer_sel_i),
    .slot_index_i   (slot_index_i),
    .interval_i     (interval_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_out_o     (slot_out_o),
    .fire_mask_o    (fire_mask_o),
    .active_count_o (active_count_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one item to the shadow tables and return the result it should give
  function automatic sched_result_t schedule_step(op_e op, bit sel, logic [2:0] idx,
                                                  logic [IVL_W-1:0] ivl);
    sched_result_t r;
    int base;
    int k;
    int n_active;
    base     = sel * SLOTS;
    n_active = 0;
    r.status = ST_OK;
    r.slot   = idx;
    r.mask   = '0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          k = base + i;
          if (slot_used[k]) begin
            if (slot_count[k] != COUNT_MAX) slot_count[k]++;
            // fire once per service; count keeps running while busy
            if (slot_count[k] >= {1'b0, slot_period[k]} && !slot_pending[k]) begin
              slot_pending[k] = 1'b1;
              slot_count[k]   = '0;
              if (i < MASK_W) r.mask[i] = 1'b1;
            end
          end
        end
      end
      OP_REGISTER: begin
        if (ivl == '0) begin
          r.status = ST_INVALID;
        end else begin
          r.status = ST_NO_FREE;
          // lowest free slot wins
          for (int i = 0; i < SLOTS && r.status == ST_NO_FREE; i++) begin
            k = base + i;
            if (!slot_used[k]) begin
              slot_used[k]    = 1'b1;
              slot_period[k]  = ivl;
              slot_count[k]   = '0;
              slot_pending[k] = 1'b0;
              r.status        = ST_OK;
              r.slot          = SLOT_OUT_W'(i);
            end
          end
        end
      end
      default: begin
        k = base + idx;
        if (idx >= SLOTS) begin
          r.status = ST_INVALID;
        end else if (!slot_used[k]) begin
          r.status = ST_NOT_REG;
        end else if (op == OP_UNREGISTER) begin
          slot_used[k]    = 1'b0;
          slot_period[k]  = '0;
          slot_count[k]   = '0;
          slot_pending[k] = 1'b0;
        end else begin
          slot_pending[k] = 1'b0;
        end
      end
    endcase
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[base + i]) n_active++;
    end
    r.active = ACTIVE_W'((n_active > ACTIVE_MAX) ? ACTIVE_MAX : n_active);
    return r;
  endfunction

  // Present one item after a random gap, wait for acceptance, record its result
  task automatic send_item(op_e op, bit sel, logic [2:0] idx, logic [IVL_W-1:0] ivl);
    int gap;
    gap = idle_en ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    timer_sel_i  <= sel;
    slot_index_i <= idx;
    interval_i   <= ivl;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(schedule_step(op, sel, idx, ivl));
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Slot picker for done/unregister: mostly live (or busy) slots, some random
  function automatic logic [2:0] pick_target(bit sel, bit want_busy);
    logic [2:0] cands[$];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[sel * SLOTS + i] && (!want_busy || slot_pending[sel * SLOTS + i]))
        cands.push_back(3'(i));
    end
    if (cands.size() == 0 || $urandom_range(0, 4) == 0) return 3'($urandom_range(0, 7));
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  // Zero interval, lowest-free allocation, largest interval, full table
  task automatic test_register_edges();
    send_item(OP_REGISTER, 1'b0, 3'd0, '0);
    send_item(OP_REGISTER, 1'b0, 3'd5, 31'd1);
    send_item(OP_REGISTER, 1'b0, 3'd2, 31'h7FFF_FFFF);
    send_item(OP_REGISTER, 1'b0, 3'd7, 31'd2);
    send_item(OP_REGISTER, 1'b0, 3'd0, 31'h2AAA_AAAA);
    send_item(OP_REGISTER, 1'b0, 3'd1, 31'h5555_5555);
    send_item(OP_REGISTER, 1'b0, 3'd3, 31'd3);
    send_item(OP_REGISTER, 1'b0, 3'd4, 31'd3);
    send_item(OP_REGISTER, 1'b0, 3'd6, 31'd4);
    send_item(OP_REGISTER, 1'b0, 3'd0, 31'd5);
  endtask

  // Firing, busy slots not refiring, tick on an empty source
  task automatic test_tick_fire();
    send_item(OP_TICK, 1'b0, 3'd0, '0);
    send_item(OP_TICK, 1'b0, 3'd3, 31'h7FFF_FFFF);
    send_item(OP_TICK, 1'b1, 3'd7, '0);
    send_item(OP_TICK, 1'b0, 3'd6, '0);
  endtask

  // Done on busy and idle slots, requests on free slots, slot reuse
  task automatic test_done_unregister();
    send_item(OP_DONE, 1'b0, 3'd0, '0);
    send_item(OP_DONE, 1'b0, 3'd1, '0);
    send_item(OP_DONE, 1'b1, 3'd3, '0);
    send_item(OP_UNREGISTER, 1'b1, 3'd5, '0);
    send_item(OP_UNREGISTER, 1'b0, 3'd3, '0);
    send_item(OP_REGISTER, 1'b1, 3'd2, 31'd1);
    send_item(OP_TICK, 1'b0, 3'd1, '0);
    send_item(OP_REGISTER, 1'b0, 3'd7, 31'd4);
  endtask

  // Mostly ticks with short intervals and done on fired slots, plus noise
  task automatic test_random_traffic(int n_items);
    int               pick;
    bit               sel;
    logic [2:0]       idx;
    logic [IVL_W-1:0] ivl;
    op_e              op;
    for (int n = 0; n < n_items; n++) begin
      idle_en = ((n / 40) % 3) != 2;
      sel  = 1'($urandom_range(0, 1));
      idx  = 3'($urandom_range(0, 7));
      ivl  = IVL_W'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        op = OP_TICK;
      end else if (pick < 65) begin
        op   = OP_REGISTER;
        pick = $urandom_range(0, 99);
        if (pick < 8) ivl = '0;
        else if (pick < 80) ivl = IVL_W'($urandom_range(1, 6));
      end else if (pick < 85) begin
        op  = OP_DONE;
        idx = pick_target(sel, 1'b1);
      end else begin
        op  = OP_UNREGISTER;
        idx = pick_target(sel, 1'b0);
      end
      send_item(op, sel, idx, ivl);
    end
    idle_en = 1'b1;
  endtask

  // Sender holds off until the pipeline is empty, then resumes
  task automatic test_drain_pause();
    wait_drained();
    send_item(OP_TICK, 1'b1, 3'd4, '0);
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin : result_check
    sched_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                 $time, status_o, slot_out_o);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", 32'(exp_r.status), 32'(status_o));
        check_field("slot_out", 32'(exp_r.slot), 32'(slot_out_o));
        check_field("fire_mask", 32'(exp_r.mask), 32'(fire_mask_o));
        check_field("active_count", 32'(exp_r.active), 32'(active_count_o));
      end
    end
  end

  // Receiver: random stall before taking each result
  initial begin : result_sink
    int stall;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_en ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Sequence
  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    op_i         <= OP_TICK;
    timer_sel_i  <= 1'b0;
    slot_index_i <= '0;
    interval_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_edges();
    test_tick_fire();
    test_done_unregister();
    test_random_traffic(290);
    test_drain_pause();
    test_random_traffic(290);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
